// ----- hw/rtl/bmg_pkg.sv -----
// Package: constants, payload types and split-multiply helpers of the Box-Muller unit.
package bmg_pkg;

    localparam int IN_BITS       = 32;
    localparam int OUT_FRAC_BITS = 28;
    localparam int OUT_SHIFT     = 92 - OUT_FRAC_BITS;

    localparam int LOG_ITERS     = 56;
    localparam int SQRT_ITERS    = 36;
    localparam int TAYLOR_TERMS  = 6;
    localparam int RAD_W         = 35;

    // stage counts of the two paths; the angle path is delayed to meet the radius
    localparam int RAD_LAT    = 1 + 2 * LOG_ITERS + 1 + 2 + SQRT_ITERS;
    localparam int TRIG_LAT   = 1 + 2 + 2 + 5 * TAYLOR_TERMS + 1;
    localparam int TRIG_DELAY = RAD_LAT - TRIG_LAT;
    localparam int SCALE_LAT  = 2;
    localparam int PIPE_LAT   = RAD_LAT + SCALE_LAT;

    localparam logic [63:0] TWO_LN2_Q62 = 64'h58B9_0BFB_E8E7_BCD6;
    localparam logic [63:0] PI_Q60      = 64'h3243_F6A8_885A_308D;
    localparam logic [60:0] ONE_Q60     = 61'h1 << 60;
    localparam logic [64:0] TWO_POW64   = 65'h1 << 64;

    typedef logic [7:0] t_div;

    localparam t_div DIV_SIN [TAYLOR_TERMS] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};
    localparam t_div DIV_COS [TAYLOR_TERMS] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};

    // floor(2^64 / d): quotient estimate is low by at most one
    localparam logic [63:0] REC_SIN [TAYLOR_TERMS] = '{
        64'(TWO_POW64 / 6),  64'(TWO_POW64 / 20),  64'(TWO_POW64 / 42),
        64'(TWO_POW64 / 72), 64'(TWO_POW64 / 110), 64'(TWO_POW64 / 156)};
    localparam logic [63:0] REC_COS [TAYLOR_TERMS] = '{
        64'(TWO_POW64 / 2),  64'(TWO_POW64 / 12),  64'(TWO_POW64 / 30),
        64'(TWO_POW64 / 56), 64'(TWO_POW64 / 90),  64'(TWO_POW64 / 132)};

    typedef struct packed {
        logic [31:0] u_first;
        logic [31:0] u_second;
    } t_in;

    typedef struct packed {
        logic signed [31:0] normal_cos;
        logic signed [31:0] normal_sin;
    } t_out;

    typedef struct packed {
        logic        cneg;
        logic [60:0] cv;
        logic        sneg;
        logic [60:0] sv;
    } t_trig;

    // four 32x32 partial products of a 64x64 multiply
    typedef struct packed {
        logic [63:0] p00;
        logic [63:0] p01;
        logic [63:0] p10;
        logic [63:0] p11;
    } t_pp;

    function automatic t_pp pp_split(input logic [63:0] a, input logic [63:0] b);
        t_pp r;
        r.p00 = 64'(a[31:0])  * 64'(b[31:0]);
        r.p01 = 64'(a[31:0])  * 64'(b[63:32]);
        r.p10 = 64'(a[63:32]) * 64'(b[31:0]);
        r.p11 = 64'(a[63:32]) * 64'(b[63:32]);
        return r;
    endfunction

    function automatic logic [127:0] pp_sum(input t_pp p);
        return {p.p11, 64'b0} + {32'b0, p.p01, 32'b0} + {32'b0, p.p10, 32'b0}
            + {64'b0, p.p00};
    endfunction

    // product shifted right, rounded half up, low 64 bits
    function automatic logic [63:0] pp_round(input t_pp p, input int unsigned sh);
        logic [127:0] v;
        v = pp_sum(p) + (128'd1 << (sh - 1));
        return 64'(v >> sh);
    endfunction

endpackage

// ----- hw/rtl/bmg_radius.sv -----
// Radius path: log2 by repeated squaring, scale to -2 ln v, digit-by-digit square root.
module bmg_radius
    import bmg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [IN_BITS-1:0] i_u,
    output logic [RAD_W-1:0]   o_radius
);

    localparam int P_W   = $clog2(IN_BITS + 1);
    localparam int T_W   = P_W + LOG_ITERS;
    localparam int Q_W   = SQRT_ITERS;
    localparam int REM_W = SQRT_ITERS + 4;

    logic [IN_BITS:0] w;
    logic [P_W-1:0]   top;
    logic [63:0]      m_init;

    // w = 2^N - u is never zero; normalize to Q1.62
    always_comb begin
        w   = {1'b1, {IN_BITS{1'b0}}} - {1'b0, i_u};
        top = '0;
        for (int i = 0; i <= IN_BITS; i++) begin
            if (w[i]) top = P_W'(i);
        end
        m_init = 64'(w) << (62 - top);
    end

    logic [63:0]          r_m  [LOG_ITERS+1];
    logic [LOG_ITERS-1:0] r_f  [LOG_ITERS+1];
    logic [P_W-1:0]       r_p  [LOG_ITERS+1];
    t_pp                  r_sq [LOG_ITERS];
    logic [LOG_ITERS-1:0] r_fa [LOG_ITERS];
    logic [P_W-1:0]       r_pa [LOG_ITERS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= m_init;
            r_f[0] <= '0;
            r_p[0] <= top;
        end
    end

    // one fraction bit of log2 per two stages
    for (genvar k = 0; k < LOG_ITERS; k++) begin : g_log
        logic [63:0] sq;
        always_comb sq = pp_round(r_sq[k], 62);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[k]  <= pp_split(r_m[k], r_m[k]);
                r_fa[k]  <= r_f[k];
                r_pa[k]  <= r_p[k];
                r_m[k+1] <= sq[63] ? {1'b0, sq[63:1]} : sq;
                r_f[k+1] <= {r_fa[k][LOG_ITERS-2:0], sq[63]};
                r_p[k+1] <= r_pa[k];
            end
        end
    end

    logic [T_W-1:0] r_t;
    t_pp            r_pp_r2;
    logic [63:0]    r_r2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t     <= {P_W'(IN_BITS) - r_p[LOG_ITERS], LOG_ITERS'(0)}
                - {P_W'(0), r_f[LOG_ITERS]};
            r_pp_r2 <= pp_split(64'(r_t), TWO_LN2_Q62);
            r_r2    <= pp_round(r_pp_r2, 62);
        end
    end

    logic [Q_W-1:0]   r_q   [SQRT_ITERS];
    logic [REM_W-1:0] r_rem [SQRT_ITERS];
    logic [63:0]      r_sr  [SQRT_ITERS-1];

    for (genvar i = 0; i < SQRT_ITERS; i++) begin : g_sqrt
        localparam int J = SQRT_ITERS - 1 - i;
        logic [Q_W-1:0]   q_in;
        logic [REM_W-1:0] rem_in;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic [63:0]      sr_in;
        logic [1:0]       two;

        if (i == 0) begin : g_first
            assign q_in   = '0;
            assign rem_in = '0;
            assign sr_in  = r_r2;
        end else begin : g_next
            assign q_in   = r_q[i-1];
            assign rem_in = r_rem[i-1];
            assign sr_in  = r_sr[i-1];
        end

        // the low digits come from the 2^8 pre-scale and are zero
        if (J >= 4) begin : g_bits
            assign two = sr_in[2*J-7 : 2*J-8];
        end else begin : g_zero
            assign two = 2'b00;
        end

        always_comb begin
            rem_sh = {rem_in[REM_W-3:0], two};
            trial  = {2'b00, q_in, 2'b01};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_sh >= trial) begin
                    r_rem[i] <= rem_sh - trial;
                    r_q[i]   <= {q_in[Q_W-2:0], 1'b1};
                end else begin
                    r_rem[i] <= rem_sh;
                    r_q[i]   <= {q_in[Q_W-2:0], 1'b0};
                end
            end
        end

        if (i < SQRT_ITERS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) r_sr[i] <= sr_in;
            end
        end
    end

    assign o_radius = r_q[SQRT_ITERS-1][RAD_W-1:0];

endmodule

// ----- hw/rtl/bmg_trig.sv -----
// Angle path: octant reduction, Taylor sine and cosine, octant mapping, alignment delay.
module bmg_trig
    import bmg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [IN_BITS-1:0] i_u,
    output t_trig              o_trig
);

    typedef struct packed {
        logic [60:0] s;
        logic [60:0] c;
        logic [60:0] x2;
        logic [2:0]  oct;
    } t_acc;

    logic [2:0]  oct_in;
    logic [60:0] g_raw;
    logic [61:0] g_red;

    always_comb begin
        oct_in = i_u[IN_BITS-1 -: 3];
        g_raw  = {i_u[IN_BITS-4:0], (64-IN_BITS)'(0)};
        // odd octants mirror about the octant boundary
        g_red  = oct_in[0] ? (62'd1 << 61) - {1'b0, g_raw} : {1'b0, g_raw};
    end

    logic [2:0]  r_oct0, r_octa, r_octb, r_octc;
    logic [61:0] r_g0;
    t_pp         r_ppx, r_ppx2;
    logic [60:0] r_x, r_xa;

    logic [60:0] r_ts  [TAYLOR_TERMS];
    logic [60:0] r_tc  [TAYLOR_TERMS];
    t_acc        r_acc [TAYLOR_TERMS+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_oct0   <= oct_in;
            r_g0     <= g_red;
            r_ppx    <= pp_split(64'(r_g0), PI_Q60);
            r_octa   <= r_oct0;
            r_x      <= 61'(pp_round(r_ppx, 63));
            r_octb   <= r_octa;
            r_ppx2   <= pp_split(64'(r_x), 64'(r_x));
            r_xa     <= r_x;
            r_octc   <= r_octb;
            r_ts[0]  <= r_xa;
            r_tc[0]  <= ONE_Q60;
            r_acc[0] <= '{s: r_xa, c: ONE_Q60, x2: 61'(pp_round(r_ppx2, 60)), oct: r_octc};
        end
    end

    t_pp         r1_pps [TAYLOR_TERMS];
    t_pp         r1_ppc [TAYLOR_TERMS];
    t_acc        r1_acc [TAYLOR_TERMS];
    logic [60:0] r2_ns  [TAYLOR_TERMS];
    logic [60:0] r2_nc  [TAYLOR_TERMS];
    t_acc        r2_acc [TAYLOR_TERMS];
    t_pp         r3_pps [TAYLOR_TERMS];
    t_pp         r3_ppc [TAYLOR_TERMS];
    logic [60:0] r3_ns  [TAYLOR_TERMS];
    logic [60:0] r3_nc  [TAYLOR_TERMS];
    t_acc        r3_acc [TAYLOR_TERMS];
    logic [60:0] r4_qs  [TAYLOR_TERMS];
    logic [60:0] r4_qc  [TAYLOR_TERMS];
    logic [60:0] r4_ns  [TAYLOR_TERMS];
    logic [60:0] r4_nc  [TAYLOR_TERMS];
    t_acc        r4_acc [TAYLOR_TERMS];

    // five stages per term: multiply, round, reciprocal multiply, take high, correct
    for (genvar k = 0; k < TAYLOR_TERMS; k++) begin : g_tay
        localparam t_div        DS  = DIV_SIN[k];
        localparam t_div        DC  = DIV_COS[k];
        localparam logic [63:0] RS  = REC_SIN[k];
        localparam logic [63:0] RC  = REC_COS[k];
        localparam bit          SUB = (k % 2) == 0;

        logic [60:0] rem_s, rem_c, qs, qc;
        t_acc        nxt;

        always_comb begin
            rem_s = r4_ns[k] - 61'(r4_qs[k] * 61'(DS));
            rem_c = r4_nc[k] - 61'(r4_qc[k] * 61'(DC));
            qs    = (rem_s >= 61'(DS)) ? r4_qs[k] + 61'd1 : r4_qs[k];
            qc    = (rem_c >= 61'(DC)) ? r4_qc[k] + 61'd1 : r4_qc[k];
            nxt   = r4_acc[k];
            if (SUB) begin
                nxt.s = r4_acc[k].s - qs;
                nxt.c = r4_acc[k].c - qc;
            end else begin
                nxt.s = r4_acc[k].s + qs;
                nxt.c = r4_acc[k].c + qc;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r1_pps[k]  <= pp_split(64'(r_ts[k]), 64'(r_acc[k].x2));
                r1_ppc[k]  <= pp_split(64'(r_tc[k]), 64'(r_acc[k].x2));
                r1_acc[k]  <= r_acc[k];
                r2_ns[k]   <= 61'(pp_round(r1_pps[k], 60));
                r2_nc[k]   <= 61'(pp_round(r1_ppc[k], 60));
                r2_acc[k]  <= r1_acc[k];
                r3_pps[k]  <= pp_split(64'(r2_ns[k]), RS);
                r3_ppc[k]  <= pp_split(64'(r2_nc[k]), RC);
                r3_ns[k]   <= r2_ns[k];
                r3_nc[k]   <= r2_nc[k];
                r3_acc[k]  <= r2_acc[k];
                r4_qs[k]   <= 61'(pp_sum(r3_pps[k]) >> 64);
                r4_qc[k]   <= 61'(pp_sum(r3_ppc[k]) >> 64);
                r4_ns[k]   <= r3_ns[k];
                r4_nc[k]   <= r3_nc[k];
                r4_acc[k]  <= r3_acc[k];
                r_acc[k+1] <= nxt;
            end
        end

        if (k < TAYLOR_TERMS - 1) begin : g_term
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ts[k+1] <= qs;
                    r_tc[k+1] <= qc;
                end
            end
        end
    end

    t_trig map;
    t_acc  fin;

    always_comb begin
        fin = r_acc[TAYLOR_TERMS];
        unique case (fin.oct)
            3'd0: map = '{cneg: 1'b0, cv: fin.c, sneg: 1'b0, sv: fin.s};
            3'd1: map = '{cneg: 1'b0, cv: fin.s, sneg: 1'b0, sv: fin.c};
            3'd2: map = '{cneg: 1'b1, cv: fin.s, sneg: 1'b0, sv: fin.c};
            3'd3: map = '{cneg: 1'b1, cv: fin.c, sneg: 1'b0, sv: fin.s};
            3'd4: map = '{cneg: 1'b1, cv: fin.c, sneg: 1'b1, sv: fin.s};
            3'd5: map = '{cneg: 1'b1, cv: fin.s, sneg: 1'b1, sv: fin.c};
            3'd6: map = '{cneg: 1'b0, cv: fin.s, sneg: 1'b1, sv: fin.c};
            3'd7: map = '{cneg: 1'b0, cv: fin.c, sneg: 1'b1, sv: fin.s};
        endcase
    end

    t_trig r_dly [TRIG_DELAY+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dly[0] <= map;
            for (int i = 1; i <= TRIG_DELAY; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    assign o_trig = r_dly[TRIG_DELAY];

endmodule

// ----- hw/rtl/bmg_scale.sv -----
// Output scaling: radius times sine and cosine, rounding, saturation and sign.
module bmg_scale
    import bmg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [RAD_W-1:0] i_radius,
    input  t_trig            i_trig,
    output t_out             o_res
);

    function automatic logic [31:0] sat_out(input logic [63:0] mag, input logic neg);
        logic [63:0] lim;
        lim = mag;
        if (neg) begin
            if (lim > 64'h8000_0000) lim = 64'h8000_0000;
            lim = 64'd0 - lim;
        end else if (lim > 64'h7FFF_FFFF) begin
            lim = 64'h7FFF_FFFF;
        end
        return lim[31:0];
    endfunction

    t_pp  r_ppc, r_pps;
    logic r_cneg, r_sneg;
    t_out r_res;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ppc            <= pp_split(64'(i_radius), 64'(i_trig.cv));
            r_pps            <= pp_split(64'(i_radius), 64'(i_trig.sv));
            r_cneg           <= i_trig.cneg;
            r_sneg           <= i_trig.sneg;
            r_res.normal_cos <= sat_out(pp_round(r_ppc, OUT_SHIFT), r_cneg);
            r_res.normal_sin <= sat_out(pp_round(r_pps, OUT_SHIFT), r_sneg);
        end
    end

    assign o_res = r_res;

endmodule

// ----- hw/rtl/bmg_outbuf.sv -----
// Two-entry output buffer that decouples the pipeline from receiver stalls.
module bmg_outbuf
    import bmg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_out i_res,
    output logic o_room,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_out       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;

    assign pop         = (r_cnt != 2'd0) && !i_out_stall;
    assign o_room      = (r_cnt != 2'd2) || pop;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_mem[r_rp];

    always_comb n_cnt = r_cnt + {1'b0, i_push} - {1'b0, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_res;
    end

endmodule

// ----- hw/rtl/box_muller_gaussian_unit.sv -----
// Box-Muller unit: takes a uniform pair per item, returns a pair of normal samples.
// Input channel: i_in_valid / o_in_stall with i_in_data (u_first, u_second, Q0.32).
// Output channel: o_out_valid / i_out_stall with o_out_data (normal_cos, normal_sin,
// signed, 28 fraction bits). An item moves on an edge where valid is high, stall low.
// Throughput: one item per clock cycle while o_in_stall stays low.
// The radius path sets the latency from the accepting input edge to the first edge
// that can take the result: one normalization stage, 112 stages of log2 squaring
// (two per fraction bit), one stage for the log offset, two for the 2 ln 2 scale,
// 36 square-root digit stages, two output scaling stages and the output buffer
// register. The angle path is shorter and is delayed to line up with the radius.
// All stages advance together; a two-entry output buffer keeps results while
// the receiver stalls. The input stalls only once that buffer is full and a
// finished item sits in the last stage.
// Reset (synchronous, active low) clears the stage valid bits and the buffer;
// items in flight are dropped. There is no configuration.
module box_muller_gaussian_unit
    import bmg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    logic [PIPE_LAT-1:0] r_vld;
    logic                en, room, push;
    logic [RAD_W-1:0]    radius;
    t_trig               trig;
    t_out                res;

    assign en         = !r_vld[PIPE_LAT-1] || room;
    assign o_in_stall = !en;
    assign push       = en && r_vld[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_in_valid};
        end
    end

    bmg_radius u_radius (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_u      (i_in_data.u_first[IN_BITS-1:0]),
        .o_radius (radius)
    );

    bmg_trig u_trig (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_u    (i_in_data.u_second[IN_BITS-1:0]),
        .o_trig (trig)
    );

    bmg_scale u_scale (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_radius (radius),
        .i_trig   (trig),
        .o_res    (res)
    );

    bmg_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_res       (res),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
